// ----- sv/assert_macros.svh -----
// Assertion macros for the screen writer RTL.
// Clock and reset are taken from the enclosing module (clk, rst_n).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_IMPL(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- sv/tsw_pkg.sv -----
// Package for the teletype screen writer: sizes, character codes, register
// indexes, controller states and screen-size helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tsw_pkg;

  localparam int MAX_COLS = 128;
  localparam int MAX_ROWS = 32;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int LEN_W    = COL_W + 1;
  localparam int CELL_AW  = ROW_W + COL_W;

  localparam logic [7:0] CH_NUL   = 8'o000;
  localparam logic [7:0] CH_BS    = 8'o010;
  localparam logic [7:0] CH_TAB   = 8'o011;
  localparam logic [7:0] CH_LF    = 8'o012;
  localparam logic [7:0] CH_CR    = 8'o015;
  localparam logic [7:0] CH_RUB   = 8'o177;
  localparam logic [7:0] CH_SPACE = 8'o040;

  localparam logic [1:0] REG_LINE_WRAP = 2'd0;
  localparam logic [1:0] REG_COLS      = 2'd1;
  localparam logic [1:0] REG_ROWS      = 2'd2;

  localparam logic FUNC_PUT  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LEN,
    S_PAD,
    S_CHAR,
    S_CELL,
    S_OUT
  } tsw_state_t;

  function automatic logic [LEN_W-1:0] eff_cols(input logic [7:0] raw);
    logic [LEN_W-1:0] w;
    if (raw == 8'd0) begin
      w = LEN_W'(1);
    end else if (int'(raw) > MAX_COLS) begin
      w = LEN_W'(MAX_COLS);
    end else begin
      w = LEN_W'(raw);
    end
    return w;
  endfunction

  function automatic logic [ROW_W:0] eff_rows(input logic [5:0] raw);
    logic [ROW_W:0] h;
    if (raw == 6'd0) begin
      h = (ROW_W + 1)'(1);
    end else if (int'(raw) > MAX_ROWS) begin
      h = (ROW_W + 1)'(MAX_ROWS);
    end else begin
      h = (ROW_W + 1)'(raw);
    end
    return h;
  endfunction

endpackage
`default_nettype wire

// ----- sv/teletype_screen_writer_unit.sv -----
// Teletype screen writer top level: control sequencer, cursor and scroll state.
// Depends on tsw_pkg, tsw_ram and assert_macros.svh.
//
// Input words (in_*): in_tuser selects put character (0) or read cell (1);
// in_tdata carries the character and the cell coordinates. Every input word
// gives exactly one output word (out_*) with the cell contents, the row length
// and the cursor position after the step.
// One word is handled at a time. The cell store and the row-length store are
// synchronous RAMs; each step reads the row length, then for a printable or a
// tab pads the line one cell per cycle where needed, up to 128 spaces, and for
// a printable writes the character. The states run S_IDLE, S_LEN, then S_PAD
// while padding, S_CHAR for a printable or S_CELL for a read within the line,
// and S_OUT, which loads the output register.
// The output register holds a finished word while out_tready is low; the
// next word is accepted meanwhile and waits before its own output load.
// Reset clears the cursor, the top-row pointer, the registers (wrap off,
// 80 columns, 24 rows) and the per-row valid bits, which make every line empty
// at once; no clearing pass is needed. Configuration writes on cfg_* take
// effect at once and clamp the cursor into the new screen size.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module teletype_screen_writer_unit
  import tsw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // char_code[7:0], read_row[12:8], read_col[19:13]
  input  wire logic        in_tuser,   // func
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // cell_char[7:0], cell_in_line[8], line_length[16:9], cursor_col[23:17], cursor_row[28:24]
  output logic [31:0]      out_tdata
);

  tsw_state_t state_r, state_nxt;

  logic             line_wrap_r, line_wrap_nxt;
  logic [7:0]       cols_raw_r, cols_raw_nxt;
  logic [5:0]       rows_raw_r, rows_raw_nxt;
  logic [COL_W-1:0] cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0] cur_row_r, cur_row_nxt;
  logic [ROW_W-1:0] top_r, top_nxt;
  logic [MAX_ROWS-1:0] len_vld_r, len_vld_nxt;
  logic             out_tvalid_r, out_tvalid_nxt;

  logic             func_r, func_nxt;
  logic [7:0]       char_r, char_nxt;
  logic [ROW_W-1:0] rrow_r, rrow_nxt;
  logic [COL_W-1:0] rcol_r, rcol_nxt;
  logic [ROW_W-1:0] prow_r, prow_nxt;
  logic [LEN_W-1:0] len_cnt_r, len_cnt_nxt;
  logic [COL_W-1:0] pad_x_r, pad_x_nxt;
  logic [7:0]       res_cell_r, res_cell_nxt;
  logic             res_inl_r, res_inl_nxt;
  logic [LEN_W-1:0] res_len_r, res_len_nxt;
  logic [31:0]      out_data_r, out_data_nxt;

  logic [7:0]       in_char;
  logic [ROW_W-1:0] in_rrow;
  logic [COL_W-1:0] in_rcol;

  logic [LEN_W-1:0] width;
  logic [ROW_W:0]   height;
  logic [COL_W-1:0] last_col;
  logic             in_acc;
  logic             out_free;

  logic             len_we;
  logic [ROW_W-1:0] len_raddr;
  logic [LEN_W-1:0] len_rdata;
  logic [LEN_W-1:0] len_cur;
  logic             cell_we;
  logic [CELL_AW-1:0] cell_waddr;
  logic [7:0]       cell_wdata;
  logic [7:0]       cell_rdata;

  logic             rd_oob;
  logic             rd_hit;
  logic             is_ignored;
  logic             is_tab;
  logic             is_print;
  logic [LEN_W-1:0] tab_next;
  logic [COL_W-1:0] tab_col;
  logic [COL_W-1:0] pad_target;
  logic             need_pad;
  logic             pad_last;
  logic             at_bottom;
  logic [ROW_W-1:0] clr_row;
  logic [LEN_W-1:0] new_w;
  logic [ROW_W:0]   new_h;

  assign in_char = in_tdata[7:0];
  assign in_rrow = in_tdata[12:8];
  assign in_rcol = in_tdata[19:13];

  assign width    = eff_cols(cols_raw_r);
  assign height   = eff_rows(rows_raw_r);
  assign last_col = COL_W'(width - LEN_W'(1));

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  // Row-length store; an entry whose valid bit is clear reads as an empty line.
  assign len_raddr = ROW_W'((in_tuser == FUNC_READ) ? top_r + in_rrow : top_r + cur_row_r);
  assign len_we    = (state_r == S_PAD);
  assign len_cur   = len_vld_r[prow_r] ? len_rdata : '0;

  tsw_ram #(.DW(LEN_W), .AW(ROW_W)) u_len_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (prow_r),
    .wdata (len_cnt_r + LEN_W'(1)),
    .raddr (len_raddr),
    .rdata (len_rdata)
  );

  always_comb begin
    cell_we    = 1'b0;
    cell_waddr = {prow_r, len_cnt_r[COL_W-1:0]};
    cell_wdata = CH_SPACE;
    if (state_r == S_PAD) begin
      cell_we = 1'b1;
    end else if (state_r == S_CHAR) begin
      cell_we    = 1'b1;
      cell_waddr = {prow_r, cur_col_r};
      cell_wdata = char_r;
    end
  end

  tsw_ram #(.DW(8), .AW(CELL_AW)) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .raddr ({prow_r, rcol_r}),
    .rdata (cell_rdata)
  );

  // Step decode, valid in S_LEN once the row length is back.
  assign rd_oob     = ({1'b0, rrow_r} >= height);
  assign rd_hit     = ({1'b0, rcol_r} < len_cur);
  assign is_ignored = (char_r == CH_NUL) || (char_r == CH_RUB);
  assign is_tab     = (char_r == CH_TAB);
  assign is_print   = !is_ignored && !is_tab && (char_r != CH_CR) && (char_r != CH_LF) &&
                      (char_r != CH_BS);
  assign tab_next   = {1'b0, cur_col_r | COL_W'(7)} + LEN_W'(1);
  always_comb begin
    tab_col = cur_col_r;
    if (cur_col_r < last_col) begin
      tab_col = (tab_next < {1'b0, last_col}) ? tab_next[COL_W-1:0] : last_col;
    end
  end
  assign pad_target = is_tab ? tab_col : cur_col_r;
  assign need_pad   = (len_cur <= {1'b0, pad_target});
  assign pad_last   = (len_cnt_r == {1'b0, pad_x_r});

  // Line feed: move down, or scroll and empty the new bottom line.
  assign at_bottom = (({1'b0, cur_row_r} + (ROW_W + 1)'(1)) >= height);
  assign clr_row   = ROW_W'(top_r + height[ROW_W-1:0]);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_LEN;
      end
      S_LEN: begin
        if (func_r == FUNC_READ) begin
          state_nxt = (!rd_oob && rd_hit) ? S_CELL : S_OUT;
        end else if (is_tab) begin
          state_nxt = need_pad ? S_PAD : S_OUT;
        end else if (is_print) begin
          state_nxt = need_pad ? S_PAD : S_CHAR;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_PAD: begin
        if (pad_last) state_nxt = is_tab ? S_OUT : S_CHAR;
      end
      S_CHAR:  state_nxt = S_OUT;
      S_CELL:  state_nxt = S_OUT;
      S_OUT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    line_wrap_nxt  = line_wrap_r;
    cols_raw_nxt   = cols_raw_r;
    rows_raw_nxt   = rows_raw_r;
    cur_col_nxt    = cur_col_r;
    cur_row_nxt    = cur_row_r;
    top_nxt        = top_r;
    len_vld_nxt    = len_vld_r;
    out_tvalid_nxt = out_tvalid_r;
    func_nxt       = func_r;
    char_nxt       = char_r;
    rrow_nxt       = rrow_r;
    rcol_nxt       = rcol_r;
    prow_nxt       = prow_r;
    len_cnt_nxt    = len_cnt_r;
    pad_x_nxt      = pad_x_r;
    res_cell_nxt   = res_cell_r;
    res_inl_nxt    = res_inl_r;
    res_len_nxt    = res_len_r;
    out_data_nxt   = out_data_r;
    new_w          = width;
    new_h          = height;

    if (out_tvalid_r && out_tready) out_tvalid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          func_nxt = in_tuser;
          char_nxt = in_char;
          rrow_nxt = in_rrow;
          rcol_nxt = in_rcol;
          prow_nxt = len_raddr;
        end
      end
      S_LEN: begin
        res_cell_nxt = '0;
        res_inl_nxt  = 1'b0;
        res_len_nxt  = '0;
        len_cnt_nxt  = len_cur;
        pad_x_nxt    = pad_target;
        if (func_r == FUNC_READ) begin
          res_cell_nxt = CH_SPACE;
          if (!rd_oob) res_len_nxt = len_cur;
        end else if (char_r == CH_CR) begin
          cur_col_nxt = '0;
        end else if (char_r == CH_LF) begin
          if (!at_bottom) begin
            cur_row_nxt = cur_row_r + ROW_W'(1);
          end else begin
            top_nxt              = top_r + ROW_W'(1);
            len_vld_nxt[clr_row] = 1'b0;
          end
        end else if (char_r == CH_BS) begin
          if (cur_col_r != '0) cur_col_nxt = cur_col_r - COL_W'(1);
        end else if (is_tab) begin
          cur_col_nxt = tab_col;
        end
      end
      S_PAD: begin
        len_cnt_nxt         = len_cnt_r + LEN_W'(1);
        len_vld_nxt[prow_r] = 1'b1;
      end
      S_CHAR: begin
        if (cur_col_r == last_col) begin
          if (line_wrap_r) begin
            cur_col_nxt = '0;
            if (!at_bottom) begin
              cur_row_nxt = cur_row_r + ROW_W'(1);
            end else begin
              top_nxt              = top_r + ROW_W'(1);
              len_vld_nxt[clr_row] = 1'b0;
            end
          end
        end else begin
          cur_col_nxt = cur_col_r + COL_W'(1);
        end
      end
      S_CELL: begin
        res_cell_nxt = cell_rdata;
        res_inl_nxt  = 1'b1;
      end
      S_OUT: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_data_nxt   = {3'b000, cur_row_r, cur_col_r, res_len_r, res_inl_r, res_cell_r};
        end
      end
      default: ;
    endcase

    if (cfg_we) begin
      case (cfg_index)
        REG_LINE_WRAP: line_wrap_nxt = cfg_wdata[0];
        REG_COLS:      cols_raw_nxt  = cfg_wdata;
        REG_ROWS:      rows_raw_nxt  = cfg_wdata[5:0];
        default: ;
      endcase
      new_w = eff_cols(cols_raw_nxt);
      new_h = eff_rows(rows_raw_nxt);
      if ({1'b0, cur_col_nxt} > new_w - LEN_W'(1)) cur_col_nxt = COL_W'(new_w - LEN_W'(1));
      if ({1'b0, cur_row_nxt} > new_h - (ROW_W + 1)'(1)) begin
        cur_row_nxt = ROW_W'(new_h - (ROW_W + 1)'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      line_wrap_r  <= 1'b0;
      cols_raw_r   <= 8'd80;
      rows_raw_r   <= 6'd24;
      cur_col_r    <= '0;
      cur_row_r    <= '0;
      top_r        <= '0;
      len_vld_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      line_wrap_r  <= line_wrap_nxt;
      cols_raw_r   <= cols_raw_nxt;
      rows_raw_r   <= rows_raw_nxt;
      cur_col_r    <= cur_col_nxt;
      cur_row_r    <= cur_row_nxt;
      top_r        <= top_nxt;
      len_vld_r    <= len_vld_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    char_r     <= char_nxt;
    rrow_r     <= rrow_nxt;
    rcol_r     <= rcol_nxt;
    prow_r     <= prow_nxt;
    len_cnt_r  <= len_cnt_nxt;
    pad_x_r    <= pad_x_nxt;
    res_cell_r <= res_cell_nxt;
    res_inl_r  <= res_inl_nxt;
    res_len_r  <= res_len_nxt;
    out_data_r <= out_data_nxt;
  end

  `ASSERT_ALWAYS(a_col_in_screen, {1'b0, cur_col_r} < width, "cursor column past line end")
  `ASSERT_ALWAYS(a_row_in_screen, {1'b0, cur_row_r} < height, "cursor row past screen end")
  `ASSERT_IMPL(a_pad_bound, state_r == S_PAD, len_cnt_r <= {1'b0, pad_x_r}, "pad overrun")
  `ASSERT_IMPL(a_char_in_line, state_r == S_CHAR, len_cnt_r > {1'b0, cur_col_r}, "char past line")
  `ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "word lost")

endmodule
`default_nettype wire

// ----- sv/tsw_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module tsw_ram #(
  parameter int DW = 8,
  parameter int AW = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
// Testbench for teletype_screen_writer_unit: random and directed put/read words,
// a scoreboard that mirrors the screen and cursor, and checks every result word.
// Depends on tsw_pkg and the RTL only.
`timescale 1ns / 1ps
module testbench;
  import tsw_pkg::*;

  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int PHASES      = 11;
  localparam int PHASE_WORDS = 115;

  typedef struct packed {
    logic [2:0] unused;
    logic [4:0] cursor_row;
    logic [6:0] cursor_col;
    logic [7:0] line_length;
    logic       cell_in_line;
    logic [7:0] cell_char;
  } screen_result_t;

  class screen_scoreboard;
    logic [7:0]     cells [MAX_COLS*MAX_ROWS];
    int unsigned    row_len [MAX_ROWS];
    int unsigned    cur_col, cur_row, top_row;
    bit             wrap_on;
    logic [7:0]     cols_raw;
    logic [5:0]     rows_raw;
    screen_result_t results_due [$];
    int             errors;

    function new();
      foreach (cells[i]) cells[i] = 8'h00;
      foreach (row_len[i]) row_len[i] = 0;
      cur_col  = 0;
      cur_row  = 0;
      top_row  = 0;
      wrap_on  = 1'b0;
      cols_raw = 8'd80;
      rows_raw = 6'd24;
      errors   = 0;
    endfunction

    function int unsigned width_now();
      if (cols_raw == 0) return 1;
      if (cols_raw > MAX_COLS) return MAX_COLS;
      return cols_raw;
    endfunction

    function int unsigned height_now();
      if (rows_raw == 0) return 1;
      if (rows_raw > MAX_ROWS) return MAX_ROWS;
      return rows_raw;
    endfunction

    function void clamp_cursor();
      if (cur_col > width_now() - 1) cur_col = width_now() - 1;
      if (cur_row > height_now() - 1) cur_row = height_now() - 1;
    endfunction

    function void feed_line();
      int unsigned h;
      h = height_now();
      if (cur_row + 1 < h) begin
        cur_row++;
      end else begin
        top_row = (top_row + 1) % MAX_ROWS;
        row_len[(top_row + h - 1) % MAX_ROWS] = 0;
      end
    endfunction

    function void pad_line(int unsigned p, int unsigned x);
      while (row_len[p] <= x && row_len[p] < MAX_COLS) begin
        cells[p*MAX_COLS + row_len[p]] = CH_SPACE;
        row_len[p]++;
      end
    endfunction

    function void put_char(logic [7:0] ch);
      int unsigned w, p, nxt;
      w = width_now();
      clamp_cursor();
      p = (top_row + cur_row) % MAX_ROWS;
      case (ch)
        CH_NUL, CH_RUB: begin
        end
        CH_CR: cur_col = 0;
        CH_LF: feed_line();
        CH_BS: begin
          if (cur_col > 0) cur_col--;
        end
        CH_TAB: begin
          if (cur_col < w - 1) begin
            nxt = (cur_col | 7) + 1;
            cur_col = (nxt < w - 1) ? nxt : w - 1;
          end
          pad_line(p, cur_col);
        end
        default: begin
          pad_line(p, cur_col);
          cells[p*MAX_COLS + cur_col] = ch;
          if (cur_col == w - 1) begin
            if (wrap_on) begin
              cur_col = 0;
              feed_line();
            end
          end else begin
            cur_col++;
          end
        end
      endcase
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        REG_LINE_WRAP: wrap_on = val[0];
        REG_COLS:      cols_raw = val;
        REG_ROWS:      rows_raw = val[5:0];
        default:       return;
      endcase
      clamp_cursor();
    endfunction

    function void note_word(logic func, logic [7:0] ch, logic [4:0] rr, logic [6:0] rc);
      screen_result_t r;
      int unsigned p;
      r = '0;
      if (func == FUNC_PUT) begin
        put_char(ch);
      end else if (rr >= height_now()) begin
        r.cell_char = CH_SPACE;
      end else begin
        p = (top_row + rr) % MAX_ROWS;
        r.line_length = 8'(row_len[p]);
        if (rc < row_len[p]) begin
          r.cell_in_line = 1'b1;
          r.cell_char = cells[p*MAX_COLS + rc];
        end else begin
          r.cell_char = CH_SPACE;
        end
      end
      r.cursor_col = 7'(cur_col);
      r.cursor_row = 5'(cur_row);
      results_due = {results_due, r};
    endfunction

    function void match_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $error("%s: expected %0d, got %0d", name, want, got);
      end
    endfunction

    function void check_word(logic [31:0] data);
      screen_result_t got, want;
      got = data;
      if (results_due.size() == 0) begin
        errors++;
        $error("result word %h with nothing pending", data);
        return;
      end
      want = results_due.pop_front();
      match_field("cell_char", want.cell_char, got.cell_char);
      match_field("cell_in_line", want.cell_in_line, got.cell_in_line);
      match_field("line_length", want.line_length, got.line_length);
      match_field("cursor_col", want.cursor_col, got.cursor_col);
      match_field("cursor_row", want.cursor_row, got.cursor_row);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // char_code[7:0], read_row[12:8], read_col[19:13]
  logic        in_tuser;   // func
  logic        out_tvalid;
  logic        out_tready;
  // cell_char[7:0], cell_in_line[8], line_length[16:9], cursor_col[23:17], cursor_row[28:24]
  logic [31:0] out_tdata;

  screen_scoreboard sb = new();
  int gap_pct = 17;
  int hold_left = 0;
  int cycle_count = 0;

  bit   phase_wrap [PHASES] = '{1, 0, 1, 1, 0, 1, 1, 0, 1, 0, 1};
  int   phase_cols [PHASES] = '{80, 128, 1, 8, 255, 0, 40, 20, 128, 17, 100};
  int   phase_rows [PHASES] = '{24, 32, 1, 2, 63, 0, 32, 5, 1, 7, 12};

  teletype_screen_writer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic send_word(input logic func, input logic [7:0] ch,
                           input logic [4:0] rr, input logic [6:0] rc);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {4'b0000, rc, rr, ch};
    do @(posedge clk); while (!in_tready);
    sb.note_word(func, ch, rr, rc);
  endtask

  task automatic put(input logic [7:0] ch);
    send_word(FUNC_PUT, ch, 5'd0, 7'd0);
  endtask

  task automatic read_at(input logic [4:0] rr, input logic [6:0] rc);
    send_word(FUNC_READ, 8'h00, rr, rc);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.results_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_screen(input bit wrap, input int cols, input int rows);
    set_reg(REG_LINE_WRAP, 8'(wrap));
    set_reg(REG_COLS, 8'(cols));
    set_reg(REG_ROWS, 8'(rows));
  endtask

  task automatic random_word();
    int unsigned sel, w, h;
    logic [7:0] ch;
    logic [4:0] rr;
    logic [6:0] rc;
    sel = $urandom_range(99);
    w   = sb.width_now();
    h   = sb.height_now();
    ch  = 8'($urandom);
    rr  = 5'($urandom);
    rc  = 7'($urandom);
    if (sel < 50) begin
      ch = ($urandom_range(9) == 0) ? 8'($urandom_range(255, 128)) : 8'($urandom_range(126, 32));
      send_word(FUNC_PUT, ch, rr, rc);
    end else if (sel < 70) begin
      case ($urandom_range(7))
        0, 1:    ch = CH_LF;
        2:       ch = CH_CR;
        3:       ch = CH_BS;
        4, 5:    ch = CH_TAB;
        6:       ch = CH_NUL;
        default: ch = CH_RUB;
      endcase
      send_word(FUNC_PUT, ch, rr, rc);
    end else if (sel < 95) begin
      rr = 5'($urandom_range(h - 1));
      rc = 7'($urandom_range((w > 127) ? 127 : w));
      send_word(FUNC_READ, ch, rr, rc);
    end else begin
      send_word(FUNC_READ, ch, rr, rc);
    end
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= gap_pct);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_word(out_tdata);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = FUNC_PUT;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: small screen with wrap, then without
    set_screen(1, 10, 3);
    read_at(5'd0, 7'd0);
    read_at(5'd31, 7'd127);
    put(8'h41);
    put(CH_TAB);
    put(8'hFF);
    put(8'h80);
    put(CH_NUL);
    put(CH_RUB);
    put(CH_BS);
    put(CH_TAB);
    put(CH_CR);
    put(CH_LF);
    put(CH_LF);
    put(8'h7E);
    read_at(5'd0, 7'd9);
    read_at(5'd1, 7'd8);
    read_at(5'd2, 7'd0);
    read_at(5'd0, 7'd127);
    drain();
    set_reg(REG_LINE_WRAP, 8'd0);
    put(CH_TAB);
    put(CH_TAB);
    put(8'h01);
    put(8'h01);
    put(CH_BS);
    read_at(5'd2, 7'd9);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      set_screen(phase_wrap[ph], phase_cols[ph], phase_rows[ph]);
      gap_pct = (ph == 0) ? 0 : 17;
      if (ph == 6) begin
        @(posedge clk);
        hold_left = 300;
      end
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (i == PHASE_WORDS / 2) drain();
        random_word();
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.results_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- teletype_screen_writer_unit.f -----
+incdir+sv
sv/tsw_pkg.sv
sv/tsw_ram.sv
sv/teletype_screen_writer_unit.sv
test/testbench.sv
